// File: sv/srx_pkg.sv
// Shared types and constants for the serial frame receiver.
package srx_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 255;

    localparam logic [7:0] HEADER_RESET  = 8'hff;
    localparam logic [7:0] ADDRESS_RESET = 8'h01;

    localparam logic [7:0] ID_HEARTBEAT = 8'hf0;
    localparam logic [7:0] ID_VELOCITY  = 8'h10;

    localparam int PADDR_W = 3;

    typedef enum logic [0:0] {
        REG_HEADER  = 1'b0,
        REG_ADDRESS = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_HB_OK    = 3'd0,
        ST_VEL_OK   = 3'd1,
        ST_OTHER_OK = 3'd2,
        ST_BAD_HDR  = 3'd3,
        ST_BAD_SUM  = 3'd4,
        ST_SHORT    = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] address_byte;
    } t_cfg;

endpackage

// File: sv/srx_if.sv
// Stream interfaces for received bytes and frame results.
interface srx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_byte;

    modport source (output valid, output rx_byte, output last_byte, input ready);
    modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface srx_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] frame_status;
    logic [7:0] frame_id;
    logic [7:0] heartbeat_value;
    logic [7:0] velocity_x;
    logic [7:0] velocity_y;
    logic [7:0] angle_byte;

    modport source (output valid, output frame_status, output frame_id,
                    output heartbeat_value, output velocity_x, output velocity_y,
                    output angle_byte, input ready);
    modport sink   (input valid, input frame_status, input frame_id,
                    input heartbeat_value, input velocity_x, input velocity_y,
                    input angle_byte, output ready);
endinterface

// File: sv/serial_frame_receiver.sv
// Serial frame receiver, with header/address/length and sum/sum-of-sums checks
// and one status transfer per frame. A byte is taken every cycle unless a last
// byte waits for the result slot; each byte passes through an input register
// and the frame logic; a frame's status enters the result register as its
// last byte leaves the input register. While a result waits, the next frame's
// bytes keep flowing; only its last byte holds in the input register until the
// result slot frees. Registers: header_byte at 0x0, address_byte at 0x4.
module serial_frame_receiver #(
    parameter int MAX_FRAME_BYTES = srx_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    srx_in_if.sink                      i_rx,
    srx_out_if.source                   o_frame,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [srx_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import srx_pkg::*;

    t_cfg cfg;

    srx_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    srx_frame_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_rx    (i_rx),
        .o_res   (o_frame)
    );

endmodule

// File: sv/srx_apb_regs.sv
// APB register block holding the header and address match bytes.
module srx_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [srx_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output srx_pkg::t_cfg               o_cfg
);
    import srx_pkg::*;

    logic [7:0] r_header;
    logic [7:0] r_address;
    logic       wr_en;
    t_reg_idx   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= HEADER_RESET;
            r_address <= ADDRESS_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_HEADER:  r_header  <= pwdata[7:0];
                REG_ADDRESS: r_address <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_HEADER:  prdata = {24'd0, r_header};
            REG_ADDRESS: prdata = {24'd0, r_address};
            default:     prdata = 32'd0;
        endcase
    end

    assign o_cfg.header_byte  = r_header;
    assign o_cfg.address_byte = r_address;

endmodule

// File: sv/srx_frame_core.sv
// Byte input register, per-frame checksum state and result register.
module srx_frame_core #(
    parameter int MAX_FRAME_BYTES = srx_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  srx_pkg::t_cfg i_cfg,
    srx_in_if.sink        i_rx,
    srx_out_if.source     o_res
);
    import srx_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

    // input register
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;

    // frame state
    logic [POS_W-1:0] r_pos,      n_pos;
    logic [7:0]       r_sum,      n_sum;
    logic [7:0]       r_sos,      n_sos;
    logic [7:0]       r_d0,       n_d0;
    logic [7:0]       r_d1,       n_d1;
    logic             r_hdr_ok,   n_hdr_ok;
    logic             r_too_long, n_too_long;
    logic [7:0]       r_id,       n_id;
    logic [7:0]       r_pl [3];
    logic [7:0]       n_pl [3];
    logic [7:0]       r_hb,       n_hb;
    logic [7:0]       r_vel [3];
    logic [7:0]       n_vel [3];

    // result register
    logic             r_res_valid;
    t_status          r_res_status, n_res_status;
    logic [7:0]       r_res_id;

    logic             advance;
    logic             proc;
    logic             too_long;
    logic             hdr;
    logic [7:0]       s;
    logic [7:0]       a;
    logic [1:0]       pl_idx;

    assign advance    = !r_res_valid || o_res.ready;
    // non-last bytes never produce a result, so they proceed during an output stall
    assign proc       = r_in_valid && (!r_in_last || advance);
    assign i_rx.ready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
            r_in_last <= i_rx.last_byte;
        end
    end

    always_comb begin
        too_long = r_too_long || (r_pos >= POS_MAX);
        hdr      = r_hdr_ok;
        if (r_pos == POS_W'(0)) begin
            hdr = (r_in_byte == i_cfg.header_byte);
        end else if (r_pos == POS_W'(1)) begin
            hdr = r_hdr_ok && (r_in_byte == i_cfg.address_byte);
        end
        s = r_sum;
        a = r_sos;
        // the two newest bytes stay out of the sums until a later byte arrives
        if (r_pos >= POS_W'(2)) begin
            s = r_sum + r_d0;
            a = r_sos + s;
        end
        pl_idx = 2'(r_pos - POS_W'(3));

        n_pos        = r_pos;
        n_sum        = r_sum;
        n_sos        = r_sos;
        n_d0         = r_d0;
        n_d1         = r_d1;
        n_hdr_ok     = r_hdr_ok;
        n_too_long   = r_too_long;
        n_id         = r_id;
        n_pl         = r_pl;
        n_hb         = r_hb;
        n_vel        = r_vel;
        n_res_status = r_res_status;

        if (proc && !r_in_last) begin
            n_sum      = s;
            n_sos      = a;
            n_d0       = r_d1;
            n_d1       = r_in_byte;
            n_hdr_ok   = hdr;
            n_too_long = too_long;
            if (r_pos == POS_W'(2)) begin
                n_id = r_in_byte;
            end else if (r_pos >= POS_W'(3) && r_pos <= POS_W'(5)) begin
                n_pl[pl_idx] = r_in_byte;
            end
            if (r_pos < POS_MAX) begin
                n_pos = r_pos + POS_W'(1);
            end
        end else if (proc) begin
            if (too_long) begin
                n_res_status = ST_BAD_SUM;
            end else if (r_pos < POS_W'(4)) begin
                n_res_status = ST_SHORT;
            end else if (!hdr) begin
                n_res_status = ST_BAD_HDR;
            end else if (s != r_d1 || a != r_in_byte) begin
                n_res_status = ST_BAD_SUM;
            end else if (r_id == ID_HEARTBEAT) begin
                if (r_pos < POS_W'(5)) begin
                    n_res_status = ST_SHORT;
                end else begin
                    n_hb         = r_pl[0];
                    n_res_status = ST_HB_OK;
                end
            end else if (r_id == ID_VELOCITY) begin
                if (r_pos < POS_W'(7)) begin
                    n_res_status = ST_SHORT;
                end else begin
                    n_vel        = r_pl;
                    n_res_status = ST_VEL_OK;
                end
            end else begin
                n_res_status = ST_OTHER_OK;
            end
            n_pos      = '0;
            n_sum      = '0;
            n_sos      = '0;
            n_d0       = '0;
            n_d1       = '0;
            n_hdr_ok   = 1'b1;
            n_too_long = 1'b0;
            n_id       = '0;
            n_pl       = '{default: 8'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_sum       <= '0;
            r_sos       <= '0;
            r_d0        <= '0;
            r_d1        <= '0;
            r_hdr_ok    <= 1'b1;
            r_too_long  <= 1'b0;
            r_id        <= '0;
            r_pl        <= '{default: 8'd0};
            r_hb        <= '0;
            r_vel       <= '{default: 8'd0};
            r_res_valid <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_sum      <= n_sum;
            r_sos      <= n_sos;
            r_d0       <= n_d0;
            r_d1       <= n_d1;
            r_hdr_ok   <= n_hdr_ok;
            r_too_long <= n_too_long;
            r_id       <= n_id;
            r_pl       <= n_pl;
            r_hb       <= n_hb;
            r_vel      <= n_vel;
            if (proc && r_in_last) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in_last) begin
            r_res_status <= n_res_status;
            r_res_id     <= r_id;
        end
    end

    // stored values only change on a last byte, which waits for the result slot
    assign o_res.valid           = r_res_valid;
    assign o_res.frame_status    = r_res_status;
    assign o_res.frame_id        = r_res_id;
    assign o_res.heartbeat_value = r_hb;
    assign o_res.velocity_x      = r_vel[0];
    assign o_res.velocity_y      = r_vel[1];
    assign o_res.angle_byte      = r_vel[2];

    a_pos_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_MAX)
        else $error("byte position beyond frame limit");

    a_last_clears_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_last) |=> (r_pos == '0 && r_hdr_ok && !r_too_long))
        else $error("frame state not cleared after last byte");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_res_valid) |-> $past(r_in_valid && r_in_last))
        else $error("result without a last byte");

    a_vel_ok_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res_status == ST_VEL_OK) |-> (r_res_id == ID_VELOCITY))
        else $error("velocity status with wrong id");

    a_stall_holds_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !o_res.ready && r_in_valid && r_in_last) |=> r_in_valid)
        else $error("last byte dropped during output stall");

endmodule

// File: dv/tb.sv
// Self-checking testbench for serial_frame_receiver: directed and random framed byte traffic, checked results.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srx_pkg::*;

    localparam int          MAX_BYTES     = MAX_FRAME_BYTES_DEF;
    localparam int unsigned LIMIT_CYCLES  = 400000;
    localparam int          DRAIN_CYCLES  = 8;
    localparam logic [10:0] STALL_PATTERN = 11'b101_1001_1101;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } rx_item_t;

    typedef struct packed {
        t_status    status;
        logic [7:0] id;
        logic [7:0] heartbeat;
        logic [7:0] vel_x;
        logic [7:0] vel_y;
        logic [7:0] angle;
    } frame_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    srx_in_if  rx_bus ();
    srx_out_if frame_bus ();

    serial_frame_receiver #(
        .MAX_FRAME_BYTES(MAX_BYTES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx_bus),
        .o_frame(frame_bus),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // Frame decoder state as the block should hold it
    logic [7:0] cfg_header  = HEADER_RESET;
    logic [7:0] cfg_address = ADDRESS_RESET;
    logic [7:0] rx_pos      = 8'd0;
    logic [7:0] acc_sum     = 8'd0;
    logic [7:0] acc_sos     = 8'd0;
    logic [7:0] lag_bytes [2] = '{8'd0, 8'd0};
    bit         hdr_match   = 1'b1;
    bit         frame_overrun = 1'b0;
    logic [7:0] id_seen     = 8'd0;
    logic [7:0] pay_seen [3] = '{8'd0, 8'd0, 8'd0};
    logic [7:0] hb_store    = 8'd0;
    logic [7:0] vel_store [3] = '{8'd0, 8'd0, 8'd0};

    frame_result_t expected_frames [$];
    rx_item_t      pending_bytes [$];
    logic [7:0]    frame_buf [$];
    int unsigned   bytes_queued = 0;
    int unsigned   bytes_taken  = 0;
    int unsigned   errors       = 0;
    int unsigned   cyc          = 0;
    int unsigned   burst_left   = 1;
    int unsigned   gap_left     = 0;
    rx_item_t      next_item;
    frame_result_t predicted;
    frame_result_t got;
    frame_result_t want;

    // Advances the decoder by one byte; returns 1 when the byte closes a frame.
    function automatic bit absorb_byte(input logic [7:0] b, input logic last,
                                       output frame_result_t r);
        int unsigned pos;
        bit          overrun;
        bit          hdr;
        logic [7:0]  s;
        logic [7:0]  a;
        t_status     st;
        pos     = rx_pos;
        overrun = frame_overrun || pos >= MAX_BYTES;
        hdr     = hdr_match;
        s       = acc_sum;
        a       = acc_sos;
        r       = '0;
        if (pos == 0) begin
            hdr = (b == cfg_header);
        end else if (pos == 1) begin
            hdr = hdr && (b == cfg_address);
        end
        // sums trail the input by two bytes so the check bytes stay out
        if (pos >= 2) begin
            s = s + lag_bytes[0];
            a = a + s;
        end
        if (!last) begin
            acc_sum      = s;
            acc_sos      = a;
            lag_bytes[0] = lag_bytes[1];
            lag_bytes[1] = b;
            hdr_match    = hdr;
            if (pos == 2) begin
                id_seen = b;
            end else if (pos >= 3 && pos <= 5) begin
                pay_seen[pos-3] = b;
            end
            frame_overrun = overrun;
            if (pos < MAX_BYTES) rx_pos = 8'(pos + 1);
            return 1'b0;
        end
        if (overrun) begin
            st = ST_BAD_SUM;
        end else if (pos + 1 < 5) begin
            st = ST_SHORT;
        end else if (!hdr) begin
            st = ST_BAD_HDR;
        end else if (s != lag_bytes[1] || a != b) begin
            st = ST_BAD_SUM;
        end else if (id_seen == ID_HEARTBEAT) begin
            if (pos + 1 < 6) begin
                st = ST_SHORT;
            end else begin
                hb_store = pay_seen[0];
                st = ST_HB_OK;
            end
        end else if (id_seen == ID_VELOCITY) begin
            if (pos + 1 < 8) begin
                st = ST_SHORT;
            end else begin
                vel_store = pay_seen;
                st = ST_VEL_OK;
            end
        end else begin
            st = ST_OTHER_OK;
        end
        r.status    = st;
        r.id        = id_seen;
        r.heartbeat = hb_store;
        r.vel_x     = vel_store[0];
        r.vel_y     = vel_store[1];
        r.angle     = vel_store[2];
        rx_pos        = 8'd0;
        acc_sum       = 8'd0;
        acc_sos       = 8'd0;
        lag_bytes     = '{8'd0, 8'd0};
        hdr_match     = 1'b1;
        frame_overrun = 1'b0;
        id_seen       = 8'd0;
        pay_seen      = '{8'd0, 8'd0, 8'd0};
        return 1'b1;
    endfunction

    task automatic check_field(input string what, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, what,
                     exp_val, act_val);
            errors++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n            = 1'b0;
        rx_bus.valid       = 1'b0;
        rx_bus.rx_byte     = 8'd0;
        rx_bus.last_byte   = 1'b0;
        frame_bus.ready    = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = 32'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Byte sender: bursts of random length, random gaps, holds while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_bus.valid <= 1'b0;
        end else begin
            if (rx_bus.valid && rx_bus.ready) begin
                if (absorb_byte(rx_bus.rx_byte, rx_bus.last_byte, predicted)) begin
                    expected_frames.push_back(predicted);
                end
                bytes_taken++;
            end
            if (!(rx_bus.valid && !rx_bus.ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    rx_bus.valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    next_item = pending_bytes.pop_front();
                    rx_bus.valid     <= 1'b1;
                    rx_bus.rx_byte   <= next_item.data;
                    rx_bus.last_byte <= next_item.last;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    rx_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: checks each result and rotates through four stall modes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_bus.ready <= 1'b0;
        end else begin
            if (frame_bus.valid && frame_bus.ready) begin
                got.status    = t_status'(frame_bus.frame_status);
                got.id        = frame_bus.frame_id;
                got.heartbeat = frame_bus.heartbeat_value;
                got.vel_x     = frame_bus.velocity_x;
                got.vel_y     = frame_bus.velocity_y;
                got.angle     = frame_bus.angle_byte;
                if (expected_frames.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, actual %0h",
                             $realtime, got);
                    errors++;
                end else begin
                    want = expected_frames.pop_front();
                    check_field("frame_status", want.status, got.status);
                    check_field("frame_id", want.id, got.id);
                    check_field("heartbeat_value", want.heartbeat, got.heartbeat);
                    check_field("velocity_x", want.vel_x, got.vel_x);
                    check_field("velocity_y", want.vel_y, got.vel_y);
                    check_field("angle_byte", want.angle, got.angle);
                end
            end
            case ((cyc / 97) % 4)
                0: frame_bus.ready <= 1'b1;
                1: frame_bus.ready <= ($urandom_range(0, 3) != 0);
                2: frame_bus.ready <= STALL_PATTERN[cyc % 11];
                default: frame_bus.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [7:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_HEADER:  cfg_header  = value;
            REG_ADDRESS: cfg_address = value;
            default: ;
        endcase
    endtask

    // Wait for every byte and every result, then let the pipeline settle
    task automatic drain();
        while (bytes_taken != bytes_queued || expected_frames.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic begin_frame(input logic [7:0] id);
        frame_buf.push_back(cfg_header);
        frame_buf.push_back(cfg_address);
        frame_buf.push_back(id);
    endtask

    // Appends sum and sum-of-sums when asked (optionally corrupted) and queues the frame
    task automatic send_frame(input bit add_check, input bit corrupt);
        logic [7:0] sum;
        logic [7:0] sos;
        int         n;
        sum = 8'd0;
        sos = 8'd0;
        if (add_check) begin
            foreach (frame_buf[k]) begin
                sum = sum + frame_buf[k];
                sos = sos + sum;
            end
            if (corrupt) begin
                if ($urandom_range(0, 1) != 0) sum = sum ^ 8'(1 << $urandom_range(0, 7));
                else sos = sos ^ 8'(1 << $urandom_range(0, 7));
            end
            frame_buf.push_back(sum);
            frame_buf.push_back(sos);
        end
        n = frame_buf.size();
        for (int k = 0; k < n; k++) begin
            pending_bytes.push_back('{data: frame_buf[k], last: (k == n - 1)});
        end
        bytes_queued += n;
        frame_buf.delete();
    endtask

    task automatic random_frame();
        int         kind;
        int         plen;
        int         pick;
        logic [7:0] id;
        kind = $urandom_range(0, 99);
        pick = $urandom_range(0, 9);
        id   = (pick < 4) ? ID_HEARTBEAT : (pick < 8) ? ID_VELOCITY : 8'($urandom);
        plen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 8);
        if (kind < 83) begin
            begin_frame(id);
            repeat (plen) frame_buf.push_back(8'($urandom));
            if (kind >= 55 && kind < 63) begin
                frame_buf[0] = frame_buf[0] ^ 8'($urandom_range(1, 255));
            end else if (kind >= 63 && kind < 71) begin
                frame_buf[1] = frame_buf[1] ^ 8'($urandom_range(1, 255));
            end
            send_frame(1'b1, kind >= 71);
        end else if (kind < 91) begin
            // too short for a frame, mostly with a proper start
            begin_frame(8'($urandom));
            repeat ($urandom_range(0, 4)) frame_buf.push_back(8'($urandom));
            while (frame_buf.size() > 4 ||
                   ($urandom_range(0, 1) != 0 && frame_buf.size() > 1)) begin
                void'(frame_buf.pop_back());
            end
            send_frame(1'b0, 1'b0);
        end else begin
            repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom));
            send_frame(1'b0, 1'b0);
        end
    endtask

    // Frame longer than the limit, with otherwise valid check bytes
    task automatic overrun_frame();
        int n;
        n = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 3);
        begin_frame(8'($urandom));
        repeat (n - 5) frame_buf.push_back(8'($urandom));
        send_frame(1'b1, 1'b0);
    endtask

    task automatic random_phase(input int unsigned budget, input bit with_overrun);
        int unsigned start;
        int unsigned slot;
        int unsigned mark;
        bit          done;
        start = bytes_queued;
        slot  = $urandom_range(0, budget / 2);
        done  = !with_overrun;
        while (bytes_queued - start < budget) begin
            if (!done && bytes_queued - start >= slot) begin
                mark = bytes_queued;
                overrun_frame();
                start += bytes_queued - mark;
                done = 1'b1;
            end else begin
                random_frame();
            end
        end
    endtask

    initial begin
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);

        // directed frames with reset register values
        frame_buf.push_back(8'h00);
        send_frame(1'b0, 1'b0);
        frame_buf.push_back(cfg_header);
        frame_buf.push_back(cfg_address);
        send_frame(1'b0, 1'b0);
        begin_frame(ID_HEARTBEAT);
        send_frame(1'b1, 1'b0);
        begin_frame(ID_HEARTBEAT);
        frame_buf.push_back(8'hff);
        send_frame(1'b1, 1'b0);
        begin_frame(ID_VELOCITY);
        frame_buf.push_back(8'h00);
        frame_buf.push_back(8'hff);
        frame_buf.push_back(8'h80);
        send_frame(1'b1, 1'b0);
        drain();

        write_reg(REG_HEADER, 8'h00);
        write_reg(REG_ADDRESS, 8'h00);
        random_phase(95, 1'b0);
        drain();

        write_reg(REG_HEADER, 8'hff);
        write_reg(REG_ADDRESS, 8'hff);
        random_phase(95, 1'b1);
        drain();

        write_reg(REG_HEADER, 8'($urandom));
        write_reg(REG_ADDRESS, 8'($urandom));
        random_phase(95, 1'b0);
        drain();

        write_reg(REG_HEADER, 8'h80);
        write_reg(REG_ADDRESS, 8'h7f);
        random_phase(95, 1'b0);
        drain();

        write_reg(REG_HEADER, HEADER_RESET);
        write_reg(REG_ADDRESS, ADDRESS_RESET);
        random_phase(95, 1'b0);
        drain();

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
